/* rtl/core/midi_voice_allocator_macros.svh */
// assertion macros shared by the voice allocator
`ifndef MIDI_VOICE_ALLOCATOR_MACROS_SVH
`define MIDI_VOICE_ALLOCATOR_MACROS_SVH

// same-cycle implication, muted while reset is asserted
`define MVA_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, muted while reset is asserted
`define MVA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* rtl/core/mva_pkg.sv */
package mva_pkg;

	localparam logic [1:0] ACT_NOTE_ON  = 2'd0;
	localparam logic [1:0] ACT_NOTE_OFF = 2'd1;
	localparam logic [1:0] ACT_PROGRAM  = 2'd2;

	localparam logic [1:0] OP_NONE    = 2'd0;
	localparam logic [1:0] OP_CLAIM   = 2'd1;
	localparam logic [1:0] OP_RELEASE = 2'd2;

	localparam logic [1:0] WAVE_HYBRID = 2'd0;
	localparam logic [1:0] WAVE_SINE   = 2'd1;
	localparam logic [1:0] WAVE_SQUARE = 2'd2;

	localparam logic [6:0] PROG_SINE_A_LO = 7'd71;
	localparam logic [6:0] PROG_SINE_A_HI = 7'd79;
	localparam logic [6:0] PROG_SQUARE    = 7'd29;
	localparam logic [6:0] PROG_SINE_B_LO = 7'd52;
	localparam logic [6:0] PROG_SINE_B_HI = 7'd54;

	// item travelling down the voice chain, result fields filled by the cell that acts
	typedef struct packed {
		logic [1:0] op;
		logic       done;
		logic [3:0] chan;
		logic [6:0] key;
		logic [6:0] amount;
		logic [1:0] wave;
		logic       hit;
		logic [3:0] voice_index;
		logic       restart_phase;
		logic       active;
		logic [6:0] note;
		logic [6:0] volume;
		logic [3:0] voice_channel;
		logic [1:0] voice_wave;
	} mva_pkt_t;

	function automatic logic [1:0] wave_for_program(input logic [6:0] prog);
		logic [1:0] w;
		priority if (prog >= PROG_SINE_A_LO && prog <= PROG_SINE_A_HI) w = WAVE_SINE;
		else if (prog == PROG_SQUARE) w = WAVE_SQUARE;
		else if (prog >= PROG_SINE_B_LO && prog <= PROG_SINE_B_HI) w = WAVE_SINE;
		else w = WAVE_HYBRID;
		return w;
	endfunction

endpackage

/* rtl/core/mva_voice_cell.sv */
module mva_voice_cell import mva_pkg::*; #(
	parameter int IDX = 0
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     in_valid,
	input  mva_pkt_t in_pkt,
	output logic     out_valid,
	output mva_pkt_t out_pkt
);

	localparam logic [3:0] IDX4 = 4'(IDX);

	logic       in_use_q;
	logic [6:0] note_q;
	logic [6:0] volume_q;
	logic [1:0] wave_q;

	logic       valid_q;
	mva_pkt_t   pkt_q;

	logic       claim_here;
	logic       rel_here;
	mva_pkt_t   pkt_nxt;

	assign claim_here = in_valid && !in_pkt.done && in_pkt.op == OP_CLAIM && !in_use_q;
	assign rel_here   = in_valid && !in_pkt.done && in_pkt.op == OP_RELEASE && in_use_q
		&& note_q == in_pkt.key;

	always_comb begin
		pkt_nxt = in_pkt;
		priority if (claim_here) begin
			pkt_nxt.done          = 1'b1;
			pkt_nxt.hit           = 1'b1;
			pkt_nxt.voice_index   = IDX4;
			pkt_nxt.restart_phase = 1'b1;
			pkt_nxt.active        = 1'b1;
			pkt_nxt.note          = in_pkt.key;
			pkt_nxt.volume        = in_pkt.amount;
			pkt_nxt.voice_channel = in_pkt.chan;
			pkt_nxt.voice_wave    = in_pkt.wave;
		end else if (rel_here) begin
			pkt_nxt.done          = 1'b1;
			pkt_nxt.hit           = 1'b1;
			pkt_nxt.voice_index   = IDX4;
			pkt_nxt.restart_phase = 1'b0;
			pkt_nxt.active        = 1'b0;
			pkt_nxt.note          = in_pkt.key;
			pkt_nxt.volume        = volume_q;
			pkt_nxt.voice_channel = 4'd0;
			pkt_nxt.voice_wave    = wave_q;
		end else begin
			pkt_nxt = in_pkt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_use_q <= 1'b0;
			valid_q  <= 1'b0;
		end else begin
			valid_q <= in_valid;
			if (claim_here) begin
				in_use_q <= 1'b1;
			end else if (rel_here) begin
				in_use_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		pkt_q <= pkt_nxt;
		if (claim_here) begin
			note_q   <= in_pkt.key;
			volume_q <= in_pkt.amount;
			wave_q   <= in_pkt.wave;
		end else if (rel_here) begin
			note_q <= in_pkt.key;
		end
	end

	assign out_valid = valid_q;
	assign out_pkt   = pkt_q;

endmodule

/* rtl/core/midi_voice_allocator.sv */
// channel   signals                                  handshake
// command   action channel key amount                start / busy
// result    hit voice_index restart_phase active     strobe, one cycle
//           note volume voice_channel wave
//
// an item walks the row of voice cells one cell per cycle, registered in each cell;
// busy falls at the edge that ends its result strobe, so the next item is taken
// after that result; the row holds a single item at a time
// program change and ignored actions also walk the row and give a no-hit result
// reset frees every voice and sets every channel to hybrid
// the receiver cannot stall: each result is shown for exactly one cycle
`include "midi_voice_allocator_macros.svh"

module midi_voice_allocator import mva_pkg::*; #(
	parameter int NUM_VOICES   = 16,
	parameter int NUM_CHANNELS = 16
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [1:0] action,
	input  logic [3:0] channel,
	input  logic [6:0] key,
	input  logic [6:0] amount,
	output logic       strobe,
	output logic       hit,
	output logic [3:0] voice_index,
	output logic       restart_phase,
	output logic       active,
	output logic [6:0] note,
	output logic [6:0] volume,
	output logic [3:0] voice_channel,
	output logic [1:0] wave
);

	localparam int CH_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

	logic [1:0]          chan_wave_q [NUM_CHANNELS];
	logic                busy_q;
	logic                accept;
	logic                chan_ok;
	logic [CH_W-1:0]     chan_idx;
	logic [1:0]          op_in;
	logic [NUM_VOICES:0] chain_valid;
	mva_pkt_t            chain_pkt [NUM_VOICES+1];

	assign accept   = start && !busy_q;
	assign chan_ok  = {1'b0, channel} < 5'(NUM_CHANNELS);
	assign chan_idx = channel[CH_W-1:0];

	always_comb begin
		unique case (action)
			ACT_NOTE_ON:  op_in = (amount == 7'd0) ? OP_RELEASE : OP_CLAIM;
			ACT_NOTE_OFF: op_in = OP_RELEASE;
			default:      op_in = OP_NONE;
		endcase
	end

	always_comb begin
		chain_pkt[0]      = '0;
		chain_pkt[0].op   = op_in;
		chain_pkt[0].done = (op_in == OP_NONE);
		chain_pkt[0].chan = channel;
		chain_pkt[0].key  = key;
		chain_pkt[0].amount = amount;
		chain_pkt[0].wave = chan_ok ? chan_wave_q[chan_idx] : WAVE_HYBRID;
	end
	assign chain_valid[0] = accept;

	for (genvar i = 0; i < NUM_VOICES; i++) begin : g_cell
		mva_voice_cell #(
			.IDX(i)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.in_valid (chain_valid[i]),
			.in_pkt   (chain_pkt[i]),
			.out_valid(chain_valid[i+1]),
			.out_pkt  (chain_pkt[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			for (int c = 0; c < NUM_CHANNELS; c++) begin
				chan_wave_q[c] <= WAVE_HYBRID;
			end
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
			end else if (chain_valid[NUM_VOICES]) begin
				busy_q <= 1'b0;
			end
			if (accept && action == ACT_PROGRAM && chan_ok) begin
				chan_wave_q[chan_idx] <= wave_for_program(amount);
			end
		end
	end

	assign busy          = busy_q;
	assign strobe        = chain_valid[NUM_VOICES];
	assign hit           = chain_pkt[NUM_VOICES].hit;
	assign voice_index   = chain_pkt[NUM_VOICES].voice_index;
	assign restart_phase = chain_pkt[NUM_VOICES].restart_phase;
	assign active        = chain_pkt[NUM_VOICES].active;
	assign note          = chain_pkt[NUM_VOICES].note;
	assign volume        = chain_pkt[NUM_VOICES].volume;
	assign voice_channel = chain_pkt[NUM_VOICES].voice_channel;
	assign wave          = chain_pkt[NUM_VOICES].voice_wave;

	`MVA_ASSERT_NOW(a_one_item_in_row, clk, arst_n, 1'b1, $countones(chain_valid[NUM_VOICES:1]) <= 1, "more than one item in the voice row")
	`MVA_ASSERT_NOW(a_strobe_busy, clk, arst_n, strobe, busy, "result strobe without an item in flight")
	`MVA_ASSERT_NOW(a_restart_hit, clk, arst_n, strobe && restart_phase, hit && active, "restart without a claimed voice")
	`MVA_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "busy not raised after accept")

endmodule
